// ===== sv/reb_pkg.sv =====
`default_nettype none
// Shared types, constants and the quadrature table for the rotary encoder event block.
package reb_pkg;

  typedef enum logic [2:0] {
    EV_CW      = 3'd0,
    EV_CCW     = 3'd1,
    EV_CLICK   = 3'd2,
    EV_LONG    = 3'd3,
    EV_TIMEOUT = 3'd4
  } event_code_t;

  // Register indexes on the APB port (byte address / 4)
  typedef enum logic [1:0] {
    REG_DEBOUNCE     = 2'd0,
    REG_LONG_PRESS   = 2'd1,
    REG_IDLE_TIMEOUT = 2'd2
  } reg_index_t;

  localparam int DEBOUNCE_W = 8;
  localparam int LONG_W     = 16;
  localparam int IDLE_W     = 20;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 8'd20;
  localparam logic [LONG_W-1:0]     LONG_RST     = 16'd1000;
  localparam logic [IDLE_W-1:0]     IDLE_RST     = 20'd10000;

  typedef struct packed {
    logic [DEBOUNCE_W-1:0] debounce_ms;
    logic [LONG_W-1:0]     long_press_ms;
    logic [IDLE_W-1:0]     idle_timeout_ms;
  } cfg_t;

  // Events produced by one item: count is 0, 1 or 2, e0 goes out first
  typedef struct packed {
    logic [1:0]  count;
    event_code_t e0;
    event_code_t e1;
  } tick_events_t;

  // 4x quadrature delta, index = {cur_ab, prev_ab}
  function automatic logic signed [2:0] quad_delta(input logic [3:0] idx);
    logic signed [2:0] d;
    case (idx)
      4'd0:    d = 3'sd0;
      4'd1:    d = 3'sd1;
      4'd2:    d = -3'sd1;
      4'd3:    d = 3'sd2;
      4'd4:    d = -3'sd1;
      4'd5:    d = 3'sd0;
      4'd6:    d = -3'sd2;
      4'd7:    d = 3'sd1;
      4'd8:    d = 3'sd1;
      4'd9:    d = -3'sd2;
      4'd10:   d = 3'sd0;
      4'd11:   d = -3'sd1;
      4'd12:   d = 3'sd2;
      4'd13:   d = -3'sd1;
      4'd14:   d = 3'sd1;
      4'd15:   d = 3'sd0;
      default: d = 3'sd0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== sv/reb_in_if.sv =====
`default_nettype none
// Input channel: one sampled tick of encoder and switch pins.
interface reb_in_if;
  logic valid;
  logic ready;
  logic pin_a;
  logic pin_b;
  logic pin_button;

  modport source (output valid, output pin_a, output pin_b, output pin_button, input ready);
  modport sink   (input valid, input pin_a, input pin_b, input pin_button, output ready);
endinterface
`default_nettype wire

// ===== sv/reb_out_if.sv =====
`default_nettype none
// Output channel: one decoded event.
interface reb_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_code;
  logic       last_of_tick;

  modport source (output valid, output event_code, output last_of_tick, input ready);
  modport sink   (input valid, input event_code, input last_of_tick, output ready);
endinterface
`default_nettype wire

// ===== sv/reb_tick_state.sv =====
`default_nettype none
// Decoder state and per-tick update: quadrature accumulator, debounce, hold and idle timers.
module reb_tick_state #(
  parameter int TIME_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  pin_a,
  input  logic                  pin_b,
  input  logic                  pin_button,
  input  reb_pkg::cfg_t         cfg,
  output reb_pkg::tick_events_t events
);
  import reb_pkg::*;

  localparam int CMP_W = (TIME_BITS > IDLE_W) ? TIME_BITS : IDLE_W;

  logic [1:0]           prev_ab;
  logic signed [2:0]    step_accum;
  logic                 button_down;
  logic                 long_done;
  logic [TIME_BITS-1:0] since_button_change;
  logic [TIME_BITS-1:0] held_time;
  logic [TIME_BITS-1:0] idle_time;

  logic [1:0]           prev_ab_next;
  logic signed [2:0]    step_accum_next;
  logic                 button_down_next;
  logic                 long_done_next;
  logic [TIME_BITS-1:0] since_button_change_next;
  logic [TIME_BITS-1:0] held_time_next;
  logic [TIME_BITS-1:0] idle_time_next;

  logic [1:0]           cur_ab;
  logic signed [2:0]    accum_sum;
  logic [TIME_BITS-1:0] sbc_inc;
  logic [TIME_BITS-1:0] held_inc;
  logic [TIME_BITS-1:0] idle_inc;
  logic                 pressed;
  logic                 enc_ev;
  event_code_t          enc_code;
  logic                 btn_ev;
  event_code_t          btn_code;
  logic                 change_ok;
  logic                 timeout_ev;

  always_comb begin
    cur_ab    = {pin_b, pin_a};
    pressed   = !pin_button;
    sbc_inc   = (&since_button_change) ? since_button_change : since_button_change + 1'b1;
    idle_inc  = (&idle_time) ? idle_time : idle_time + 1'b1;
    held_inc  = (button_down && !(&held_time)) ? held_time + 1'b1 : held_time;

    // encoder
    accum_sum    = step_accum + quad_delta({cur_ab, prev_ab});
    prev_ab_next = cur_ab;
    enc_ev       = 1'b0;
    enc_code     = EV_CW;
    if (accum_sum >= 3'sd2) begin
      enc_ev          = 1'b1;
      step_accum_next = 3'sd0;
    end else if (accum_sum <= -3'sd2) begin
      enc_ev          = 1'b1;
      enc_code        = EV_CCW;
      step_accum_next = 3'sd0;
    end else begin
      step_accum_next = accum_sum;
    end

    // switch
    button_down_next         = button_down;
    long_done_next           = long_done;
    since_button_change_next = sbc_inc;
    held_time_next           = held_inc;
    btn_ev                   = 1'b0;
    btn_code                 = EV_CLICK;
    change_ok = (pressed != button_down) &&
                (CMP_W'(sbc_inc) > CMP_W'(cfg.debounce_ms));
    if (change_ok) begin
      since_button_change_next = '0;
      if (pressed) begin
        button_down_next = 1'b1;
        held_time_next   = '0;
        long_done_next   = 1'b0;
      end else begin
        button_down_next = 1'b0;
        if (CMP_W'(held_inc) < CMP_W'(cfg.long_press_ms)) begin
          btn_ev = 1'b1;
        end
      end
    end
    if (button_down_next && !long_done_next &&
        (CMP_W'(held_time_next) > CMP_W'(cfg.long_press_ms))) begin
      btn_ev         = 1'b1;
      btn_code       = EV_LONG;
      long_done_next = 1'b1;
    end

    // idle timeout only when nothing else fired this tick and the switch is up
    timeout_ev = !enc_ev && !btn_ev && !button_down_next &&
                 (CMP_W'(idle_inc) > CMP_W'(cfg.idle_timeout_ms));
    idle_time_next = (enc_ev || btn_ev || timeout_ev) ? '0 : idle_inc;

    events.e1 = btn_code;
    if (enc_ev && btn_ev) begin
      events.count = 2'd2;
      events.e0    = enc_code;
    end else if (enc_ev) begin
      events.count = 2'd1;
      events.e0    = enc_code;
    end else if (btn_ev) begin
      events.count = 2'd1;
      events.e0    = btn_code;
    end else if (timeout_ev) begin
      events.count = 2'd1;
      events.e0    = EV_TIMEOUT;
    end else begin
      events.count = 2'd0;
      events.e0    = EV_CW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_ab             <= '0;
      step_accum          <= '0;
      button_down         <= 1'b0;
      long_done           <= 1'b0;
      since_button_change <= '1;
      held_time           <= '0;
      idle_time           <= '0;
    end else if (step) begin
      prev_ab             <= prev_ab_next;
      step_accum          <= step_accum_next;
      button_down         <= button_down_next;
      long_done           <= long_done_next;
      since_button_change <= since_button_change_next;
      held_time           <= held_time_next;
      idle_time           <= idle_time_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/reb_result_buf.sv =====
`default_nettype none
// Two-entry result register that hands out the events of one item in order.
module reb_result_buf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  reb_pkg::tick_events_t events,
  output logic                  can_load,
  reb_out_if.source             out_ch
);
  import reb_pkg::*;

  logic [1:0]  left;
  event_code_t e0;
  event_code_t e1;
  logic        out_fire;

  assign out_fire            = out_ch.valid && out_ch.ready;
  assign can_load            = (left == 2'd0) || ((left == 2'd1) && out_ch.ready);
  assign out_ch.valid        = (left != 2'd0);
  assign out_ch.event_code   = e0;
  assign out_ch.last_of_tick = (left == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= 2'd0;
    end else if (load) begin
      left <= events.count;
    end else if (out_fire) begin
      left <= left - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      e0 <= events.e0;
      e1 <= events.e1;
    end else if (out_fire) begin
      e0 <= e1;
    end
  end

endmodule
`default_nettype wire

// ===== sv/rotary_encoder_button_events_core.sv =====
`default_nettype none
// Rotary encoder and push-button event decoder. Each input item is one 1 ms
// sample of encoder pins A/B and the active-low switch. An accepted item sits
// in an input register until the two-entry result register can take it, is
// decoded in a single pass and leaves zero, one or two events there. One item
// is accepted per clock while none is kept waiting; the output port moves one
// event per clock while the receiver is ready, so an item with two events (a
// rotation step plus a click or long click in the same tick) holds the input
// until its first event is taken. Settings must be written over the APB port
// (0x0 debounce_ms, 0x4 long_press_ms, 0x8 idle_timeout_ms) only while no
// item is in flight; the block itself does not enforce this.
module rotary_encoder_button_events_core #(
  parameter int TIME_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  reb_in_if.sink      in_ch,
  reb_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import reb_pkg::*;

  cfg_t         cfg;
  logic         cfg_wr;
  reg_index_t   reg_sel;
  logic         inq_valid;
  logic         inq_a;
  logic         inq_b;
  logic         inq_button;
  logic         can_load;
  logic         advance;
  tick_events_t events;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms     <= DEBOUNCE_RST;
      cfg.long_press_ms   <= LONG_RST;
      cfg.idle_timeout_ms <= IDLE_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_DEBOUNCE:     cfg.debounce_ms     <= pwdata[DEBOUNCE_W-1:0];
        REG_LONG_PRESS:   cfg.long_press_ms   <= pwdata[LONG_W-1:0];
        REG_IDLE_TIMEOUT: cfg.idle_timeout_ms <= pwdata[IDLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DEBOUNCE:     prdata = 32'(cfg.debounce_ms);
      REG_LONG_PRESS:   prdata = 32'(cfg.long_press_ms);
      REG_IDLE_TIMEOUT: prdata = 32'(cfg.idle_timeout_ms);
      default:          prdata = '0;
    endcase
  end

  // input register
  assign advance     = inq_valid && can_load;
  assign in_ch.ready = !inq_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_ch.ready) begin
      inq_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      inq_a      <= in_ch.pin_a;
      inq_b      <= in_ch.pin_b;
      inq_button <= in_ch.pin_button;
    end
  end

  reb_tick_state #(
    .TIME_BITS (TIME_BITS)
  ) u_state (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .pin_a      (inq_a),
    .pin_b      (inq_b),
    .pin_button (inq_button),
    .cfg        (cfg),
    .events     (events)
  );

  reb_result_buf u_result (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .events   (events),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

`ifndef ASSERT_OFF
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    inq_valid && !can_load |-> !in_ch.ready)
    else $error("input taken while decoded item is stalled");

  a_second_event: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.ready && !out_ch.last_of_tick |=>
      out_ch.valid && out_ch.last_of_tick)
    else $error("first of two events not followed by the closing event");

  a_timeout_alone: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.event_code == EV_TIMEOUT) |-> out_ch.last_of_tick)
    else $error("timeout event shares a tick with another event");
`endif

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the rotary encoder and push-button event core.
module testbench;
  import reb_pkg::*;

  localparam int          CYCLE_LIMIT   = 300000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          MAX_REPORTS   = 10;
  localparam logic [19:0] TIME_MAX      = 20'hFFFFF;
  localparam logic [1:0]  REG_UNUSED    = 2'd3;

  typedef struct packed {
    event_code_t code;
    logic        last;
  } event_item_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  reb_in_if  in_ch ();
  reb_out_if out_ch ();

  rotary_encoder_button_events_core DUT (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder state kept by the testbench
  logic [7:0]  cfg_debounce;
  logic [15:0] cfg_long;
  logic [19:0] cfg_idle;
  logic [1:0]  enc_prev;
  int          enc_accum;
  logic        sw_down;
  logic        long_sent;
  logic [19:0] since_sw_change;
  logic [19:0] hold_ms;
  logic [19:0] quiet_ms;

  event_item_t pending_events[$];

  int   errors = 0;
  int   ticks_sent = 0;
  int   cfg_writes = 0;
  int   cycle_count = 0;
  int   seen_by_code[5] = '{0, 0, 0, 0, 0};
  bit   rx_stalls_on = 1'b1;
  bit   tx_gaps_on = 1'b1;
  int   rx_hold_cycles = 0;

  // random stimulus generator state
  logic [1:0] gen_pos = 2'd0;
  logic [1:0] gen_dir = 2'd1;
  logic       gen_btn = 1'b1;
  int         gen_run = 0;
  int         gen_still = 0;

  // position of an A/B pair along the gray cycle 00, 01, 11, 10 ({b, a})
  function automatic logic [1:0] quad_pos(input logic [1:0] ab);
    return {ab[1], ab[0] ^ ab[1]};
  endfunction

  task automatic predict_tick(input logic a, input logic b, input logic btn);
    event_code_t evs [2];
    int          n;
    logic [1:0]  cur;
    logic [1:0]  step;
    logic        pressed;
    n = 0;
    cur = {b, a};
    pressed = ~btn;
    if (since_sw_change != TIME_MAX) since_sw_change++;
    if (quiet_ms != TIME_MAX) quiet_ms++;
    if (sw_down && hold_ms != TIME_MAX) hold_ms++;

    // forward along the cycle counts down; a skipped state counts two by old pattern
    step = quad_pos(cur) - quad_pos(enc_prev);
    case (step)
      2'd1: enc_accum -= 1;
      2'd3: enc_accum += 1;
      2'd2: enc_accum += (enc_prev[0] == enc_prev[1]) ? 2 : -2;
      default: ;
    endcase
    enc_prev = cur;
    if (enc_accum >= 2) begin
      evs[n] = EV_CW;
      n++;
      enc_accum = 0;
    end else if (enc_accum <= -2) begin
      evs[n] = EV_CCW;
      n++;
      enc_accum = 0;
    end

    if (pressed != sw_down && since_sw_change > {12'd0, cfg_debounce}) begin
      since_sw_change = '0;
      if (pressed) begin
        sw_down = 1'b1;
        hold_ms = '0;
        long_sent = 1'b0;
      end else begin
        sw_down = 1'b0;
        if (hold_ms < {4'd0, cfg_long}) begin
          evs[n] = EV_CLICK;
          n++;
        end
      end
    end

    if (sw_down && !long_sent && hold_ms > {4'd0, cfg_long}) begin
      evs[n] = EV_LONG;
      n++;
      long_sent = 1'b1;
    end

    if (n > 0) begin
      quiet_ms = '0;
    end else if (!sw_down && quiet_ms > cfg_idle) begin
      evs[n] = EV_TIMEOUT;
      n++;
      quiet_ms = '0;
    end

    for (int k = 0; k < n; k++) begin
      pending_events.push_back('{code: evs[k], last: (k == n - 1)});
    end
  endtask

  task automatic send_tick(input logic a, input logic b, input logic btn);
    in_ch.valid      <= 1'b1;
    in_ch.pin_a      <= a;
    in_ch.pin_b      <= b;
    in_ch.pin_button <= btn;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_tick(a, b, btn);
    ticks_sent++;
  endtask

  task automatic idle_gap();
    in_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 11)) @(posedge clk);
  endtask

  // stop offering items and wait out every pending event plus the pipeline
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_DEBOUNCE:     cfg_debounce = val[7:0];
      REG_LONG_PRESS:   cfg_long = val[15:0];
      REG_IDLE_TIMEOUT: cfg_idle = val[19:0];
      default: ;
    endcase
    cfg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // upper bits beyond each register's width carry junk that must be dropped
  task automatic set_config(input int deb, input int lng, input int idl);
    wait_drained();
    cfg_write(REG_DEBOUNCE, {24'($urandom_range(0, 32'hFFFFFF)), 8'(deb)});
    cfg_write(REG_LONG_PRESS, {16'($urandom_range(0, 16'hFFFF)), 16'(lng)});
    cfg_write(REG_IDLE_TIMEOUT, {12'($urandom_range(0, 12'hFFF)), 20'(idl)});
  endtask

  // mostly clean quadrature walks and held switch levels, with some noise
  task automatic random_ticks(input int count, input int run_max);
    int   i;
    int   r;
    logic btn;
    for (i = 0; i < count; i++) begin
      if (tx_gaps_on && $urandom_range(0, 4) == 0) idle_gap();
      if (tx_gaps_on && $urandom_range(0, 59) == 0) wait_drained();
      if (gen_still > 0) begin
        gen_still--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          gen_still = $urandom_range(3, 15);
        end else if (r < 74) begin
          gen_pos += gen_dir;
          if ($urandom_range(0, 11) == 0) gen_dir = 2'd0 - gen_dir;
        end else if (r >= 86 && r < 94) begin
          gen_pos += 2'd2;
        end else if (r >= 94) begin
          gen_pos = 2'($urandom_range(0, 3));
        end
      end
      if (gen_run == 0) begin
        gen_btn = ~gen_btn;
        gen_run = $urandom_range(1, run_max);
      end else begin
        gen_run--;
      end
      btn = gen_btn;
      if ($urandom_range(0, 24) == 0) btn = ~btn;  // one-tick bounce
      send_tick(gen_pos[0] ^ gen_pos[1], gen_pos[1], btn);
    end
  endtask

  // rotation both ways, double steps, click, long click, release exactly at
  // the long-press time, a step and a click in one tick, idle timeout
  task automatic test_directed_events();
    set_config(0, 2, 3);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);
    repeat (5) send_tick(1'b0, 1'b0, 1'b0);
    repeat (3) send_tick(1'b0, 1'b0, 1'b1);
  endtask

  // bounces inside the debounce window are dropped without restarting it;
  // zero long-press and zero idle times; a write to an unmapped address
  task automatic test_directed_bounce();
    set_config(3, 0, 0);
    cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0);
    repeat (4) send_tick(1'b0, 1'b0, 1'b1);
  endtask

  task automatic test_reset_settings();
    set_config(int'(DEBOUNCE_RST), int'(LONG_RST), int'(IDLE_RST));
    random_ticks(90, 40);
  endtask

  task automatic test_fast_settings();
    set_config(0, 3, 6);
    random_ticks(110, 8);
  endtask

  task automatic test_high_extremes();
    set_config(255, 65535, 1048575);
    random_ticks(80, 300);
  endtask

  task automatic test_low_extremes();
    set_config(0, 0, 0);
    random_ticks(100, 5);
  endtask

  task automatic test_random_settings();
    repeat (3) begin
      set_config($urandom_range(0, 6), $urandom_range(0, 10), $urandom_range(0, 30));
      random_ticks(60, 14);
    end
  endtask

  // receiver holds off while items keep coming, so the core must stall its input
  task automatic test_backpressure();
    int i;
    set_config(0, 3, 6);
    rx_hold_cycles = 150;
    for (i = 0; i < 40; i++) begin
      gen_pos += 2'd1;
      send_tick(gen_pos[0] ^ gen_pos[1], gen_pos[1], ((i / 5) % 2) == 0);
    end
    wait_drained();
  endtask

  task automatic test_no_idling();
    set_config($urandom_range(0, 4), $urandom_range(0, 8), $urandom_range(0, 20));
    rx_stalls_on = 1'b0;
    tx_gaps_on = 1'b0;
    random_ticks(100, 10);
  endtask

  // receiver ready: long hold-offs on request, random stall bursts otherwise
  initial begin
    int hold;
    forever begin
      if (rx_hold_cycles > 0) begin
        hold = rx_hold_cycles;
        rx_hold_cycles = 0;
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic report_mismatch(input string what, input event_item_t want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch (%s): expected code %0d last %0b, got code %0d last %0b",
               what, want.code, want.last, out_ch.event_code, out_ch.last_of_tick);
  endtask

  always @(posedge clk) begin
    event_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (out_ch.event_code < 3'd5) seen_by_code[out_ch.event_code]++;
      if (pending_events.size() == 0) begin
        report_mismatch("no event pending", '{code: EV_TIMEOUT, last: 1'b1});
      end else begin
        want = pending_events.pop_front();
        if (out_ch.event_code !== want.code || out_ch.last_of_tick !== want.last)
          report_mismatch("field", want);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events outstanding",
               cycle_count, pending_events.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst              <= 1'b1;
    in_ch.valid      <= 1'b0;
    in_ch.pin_a      <= 1'b0;
    in_ch.pin_b      <= 1'b0;
    in_ch.pin_button <= 1'b1;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    cfg_debounce    = DEBOUNCE_RST;
    cfg_long        = LONG_RST;
    cfg_idle        = IDLE_RST;
    enc_prev        = 2'd0;
    enc_accum       = 0;
    sw_down         = 1'b0;
    long_sent       = 1'b0;
    since_sw_change = TIME_MAX;
    hold_ms         = '0;
    quiet_ms        = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_events();
    test_directed_bounce();
    test_reset_settings();
    test_fast_settings();
    test_backpressure();
    test_high_extremes();
    test_low_extremes();
    test_random_settings();
    test_no_idling();

    wait_drained();
    repeat (10) @(posedge clk);
    if (pending_events.size() != 0) begin
      errors += pending_events.size();
      $display("%0d events never arrived", pending_events.size());
    end
    $display("ran %0d ticks over %0d register writes; events cw %0d ccw %0d click %0d",
             ticks_sent, cfg_writes, seen_by_code[0], seen_by_code[1], seen_by_code[2]);
    $display("long click %0d, timeout %0d; %0d mismatches",
             seen_by_code[3], seen_by_code[4], errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
